@@ sv/mdts_pkg.sv @@
// ----------------------------------------------------------------------------
// mdts_pkg
// Types, character codes and the inline span step shared by the scanner.
// ----------------------------------------------------------------------------
package mdts_pkg;

  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam logic [2:0] TT_HEAD = 3'd0;
  localparam logic [2:0] TT_BOLD = 3'd1;
  localparam logic [2:0] TT_EMPH = 3'd2;
  localparam logic [2:0] TT_CODE = 3'd3;
  localparam logic [2:0] TT_LINK = 3'd4;

  // inline span scan
  typedef enum logic [7:0] {
    SM_IDLE   = 8'b0000_0001,
    SM_CODE   = 8'b0000_0010,
    SM_BOLD   = 8'b0000_0100,
    SM_ITALIC = 8'b0000_1000,
    SM_LTEXT  = 8'b0001_0000,
    SM_LAFTER = 8'b0010_0000,
    SM_LURL   = 8'b0100_0000,
    SM_STAR   = 8'b1000_0000
  } scan_mode_t;

  // line prefix classification
  typedef enum logic [8:0] {
    PC_SPACES = 9'b0_0000_0001,
    PC_BT1    = 9'b0_0000_0010,
    PC_BT2    = 9'b0_0000_0100,
    PC_TL1    = 9'b0_0000_1000,
    PC_TL2    = 9'b0_0001_0000,
    PC_FENCE  = 9'b0_0010_0000,
    PC_CODE   = 9'b0_0100_0000,
    PC_HEAD   = 9'b0_1000_0000,
    PC_INLINE = 9'b1_0000_0000
  } prefix_t;

  typedef struct packed {
    scan_mode_t  mode;
    logic [11:0] span_start;
    logic [7:0]  prev;       // previous byte of the line
    logic        star_prev;  // byte before a pending '*' was '*'
    logic        bold_star;  // previous bold content byte was '*'
  } iscan_t;

  typedef struct packed {
    iscan_t      st;
    logic        hit;
    logic [11:0] start;
    logic [12:0] len;
    logic [2:0]  typ;
  } step_t;

  typedef struct packed {
    logic        code_block;
    logic [15:0] line_number;
    logic [15:0] last_line;
    logic [11:0] last_col;
    logic [12:0] col_count;
    prefix_t     pclass;
    iscan_t      isc;
  } scan_state_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] row_delta;
    logic [11:0] col_delta;
    logic [12:0] token_length;
    logic [2:0]  token_type;
  } tok_t;

  localparam iscan_t ISCAN_RESET = '{
    mode: SM_IDLE, span_start: 12'd0, prev: 8'd0, star_prev: 1'b0, bold_star: 1'b0
  };

  localparam scan_state_t STATE_RESET = '{
    code_block: 1'b0, line_number: 16'd0, last_line: 16'd0, last_col: 12'd0,
    col_count: 13'd0, pclass: PC_SPACES, isc: ISCAN_RESET
  };

  function automatic iscan_t idle_open(iscan_t s, logic [7:0] b, logic [11:0] pos);
    iscan_t r;
    r = s;
    if (b == CH_BTICK) begin
      r.mode       = SM_CODE;
      r.span_start = pos;
    end else if (b == CH_STAR) begin
      r.mode       = SM_STAR;
      r.span_start = pos;
      r.star_prev  = (s.prev == CH_STAR);
    end else if (b == CH_LBRK) begin
      r.mode       = SM_LTEXT;
      r.span_start = pos;
    end
    return r;
  endfunction

  // One byte through the inline span scan.
  function automatic step_t inline_step(iscan_t s, logic [7:0] b, logic [11:0] pos);
    step_t r;
    r.st    = s;
    r.hit   = 1'b0;
    r.start = s.span_start;
    r.len   = {1'b0, pos} - {1'b0, s.span_start} + 13'd1;
    r.typ   = TT_CODE;
    unique case (s.mode)
      SM_IDLE: r.st = idle_open(s, b, pos);
      SM_CODE: begin
        if (b == CH_BTICK) begin
          r.st.mode = SM_IDLE;
          r.hit     = 1'b1;
        end
      end
      SM_BOLD: begin
        if (b == CH_STAR && s.bold_star) begin
          r.st.mode = SM_IDLE;
          r.hit     = 1'b1;
          r.typ     = TT_BOLD;
        end else begin
          r.st.bold_star = (b == CH_STAR);
        end
      end
      SM_ITALIC: begin
        if (b == CH_STAR) begin
          r.st.mode = SM_IDLE;
          r.hit     = 1'b1;
          r.typ     = TT_EMPH;
        end
      end
      SM_LTEXT: begin
        if (b == CH_RBRK) r.st.mode = SM_LAFTER;
      end
      SM_LAFTER: begin
        if (b == CH_LPAR) begin
          r.st.mode = SM_LURL;
        end else begin
          r.st.mode = SM_IDLE;
          r.st      = idle_open(r.st, b, pos);
        end
      end
      SM_LURL: begin
        if (b == CH_RPAR) begin
          r.st.mode = SM_IDLE;
          r.hit     = 1'b1;
          r.typ     = TT_LINK;
        end
      end
      SM_STAR: begin
        if (b == CH_STAR) begin
          r.st.mode      = SM_BOLD;
          r.st.bold_star = 1'b0;
        end else if (s.star_prev || b == CH_SPACE) begin
          r.st.mode = SM_IDLE;
          r.st      = idle_open(r.st, b, pos);
        end else begin
          r.st.mode = SM_ITALIC;
        end
      end
      default: r.st = s;
    endcase
    r.st.prev = b;
    return r;
  endfunction

endpackage

@@ sv/mdts_ifs.sv @@
// ----------------------------------------------------------------------------
// mdts channel interfaces
// Valid/ready channels for text words in and token words out.
// ----------------------------------------------------------------------------
interface mdts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       closes_line;
  logic       starts_document;

  modport source (output valid, output text_byte, output closes_line,
                  output starts_document, input ready);
  modport sink   (input valid, input text_byte, input closes_line,
                  input starts_document, output ready);
endinterface

interface mdts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_delta;
  logic [11:0] col_delta;
  logic [12:0] token_length;
  logic [2:0]  token_type;

  modport source (output valid, output row_delta, output col_delta,
                  output token_length, output token_type, input ready);
  modport sink   (input valid, input row_delta, input col_delta,
                  input token_length, input token_type, output ready);
endinterface

@@ sv/markdown_token_scanner.sv @@
// ----------------------------------------------------------------------------
// markdown_token_scanner
// Markdown semantic token scanner: text words in, delta-encoded tokens out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                              words
//  in_chan  in   text_byte, closes_line, starts_document              text
//  out_chan out  row_delta, col_delta, token_length, token_type       tokens
//
//  A word passes the input register, then the scan logic into the
//  token register. One word per cycle is taken, but for the stall below;
//  the mode registers are updated in the cycle the word leaves the input register.
//  rst_n is synchronous; counters clear to zero, modes to SM_IDLE/PC_SPACES.
//  A word that yields no token moves on even while a token waits on
//  out_chan; a word that yields one waits for the token register to free.
// ----------------------------------------------------------------------------
module markdown_token_scanner #(
  parameter int MAX_LINE_LEN = 4096,
  parameter int MAX_LINES    = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  mdts_in_if.sink           in_chan,
  mdts_out_if.source        out_chan
);
  import mdts_pkg::*;

  localparam int COL_CAP_I  = (MAX_LINE_LEN < 4096) ? MAX_LINE_LEN : 4096;
  localparam int LINE_CAP_I = (MAX_LINES < 65536) ? MAX_LINES - 1 : 65535;
  localparam logic [12:0] COL_CAP  = 13'(COL_CAP_I);
  localparam logic [15:0] LINE_CAP = 16'(LINE_CAP_I);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_close_r;
  logic        in_sod_r;
  scan_state_t state_r, state_nxt;
  tok_t        tok;
  logic        adv;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_dl_r;
  logic [11:0] out_ds_r;
  logic [12:0] out_len_r;
  logic [2:0]  out_type_r;

  mdts_scan #(
    .MAX_LINE_LEN (MAX_LINE_LEN),
    .MAX_LINES    (MAX_LINES)
  ) u_scan (
    .cur             (state_r),
    .text_byte       (in_byte_r),
    .closes_line     (in_close_r),
    .starts_document (in_sod_r),
    .nxt             (state_nxt),
    .tok             (tok)
  );

  assign adv           = in_valid_r && (!out_valid_r || out_chan.ready || !tok.hit);
  assign in_chan.ready = !in_valid_r || adv;
  assign out_valid_nxt = (adv && tok.hit) || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_chan.ready) in_valid_r <= in_chan.valid;
      if (adv) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready) begin
      in_byte_r  <= in_chan.text_byte;
      in_close_r <= in_chan.closes_line;
      in_sod_r   <= in_chan.starts_document;
    end
    if (adv && tok.hit) begin
      out_dl_r   <= tok.row_delta;
      out_ds_r   <= tok.col_delta;
      out_len_r  <= tok.token_length;
      out_type_r <= tok.token_type;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.row_delta    = out_dl_r;
  assign out_chan.col_delta    = out_ds_r;
  assign out_chan.token_length = out_len_r;
  assign out_chan.token_type   = out_type_r;

`ifndef SYNTHESIS
  a_tok_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("token word appeared without a text word in flight");

  a_line_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.line_number <= LINE_CAP)
    else $error("line number passed its cap");

  a_col_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.col_count <= COL_CAP)
    else $error("column count passed its cap");

  a_prefix_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pclass == PC_SPACES |-> state_r.isc.mode == SM_IDLE)
    else $error("inline span open before any non-space byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready && tok.hit |-> !adv)
    else $error("token would overwrite a waiting token word");
`endif

endmodule

@@ sv/mdts_scan.sv @@
// ----------------------------------------------------------------------------
// mdts_scan
// Next-state and token logic for one text word: line prefix class, fence
// candidate replay, inline span scan and delta encoding.
// ----------------------------------------------------------------------------
module mdts_scan #(
  parameter int MAX_LINE_LEN = 4096,
  parameter int MAX_LINES    = 65536
) (
  input  mdts_pkg::scan_state_t cur,
  input  logic [7:0]            text_byte,
  input  logic                  closes_line,
  input  logic                  starts_document,
  output mdts_pkg::scan_state_t nxt,
  output mdts_pkg::tok_t        tok
);
  import mdts_pkg::*;

  localparam int COL_CAP_I  = (MAX_LINE_LEN < 4096) ? MAX_LINE_LEN : 4096;
  localparam int LINE_CAP_I = (MAX_LINES < 65536) ? MAX_LINES - 1 : 65535;
  localparam logic [12:0] COL_CAP  = 13'(COL_CAP_I);
  localparam logic [12:0] COL_LAST = 13'(COL_CAP_I - 1);
  localparam logic [15:0] LINE_CAP = 16'(LINE_CAP_I);

  scan_state_t s;
  step_t       st_a, st_b, st_c;
  iscan_t      mid_st, c_in;
  logic        cand, cnt2, rep_hit, use_b;
  logic [7:0]  fc;
  logic [11:0] pos, p1;
  logic [12:0] p1_sum;
  logic        hit;
  logic [11:0] t_start;
  logic [12:0] t_len;
  logic [2:0]  t_type;
  logic [15:0] dl;

  assign s = starts_document ? STATE_RESET : cur;

  assign cand = (s.pclass == PC_BT1) || (s.pclass == PC_BT2) ||
                (s.pclass == PC_TL1) || (s.pclass == PC_TL2);
  assign cnt2 = (s.pclass == PC_BT2) || (s.pclass == PC_TL2);
  assign fc   = ((s.pclass == PC_BT1) || (s.pclass == PC_BT2)) ? CH_BTICK : CH_TILDE;

  assign pos    = (s.col_count < COL_LAST) ? s.col_count[11:0] : COL_LAST[11:0];
  assign p1_sum = {1'b0, s.isc.span_start} + 13'd1;
  assign p1     = (p1_sum < COL_LAST) ? p1_sum[11:0] : COL_LAST[11:0];

  // held fence bytes replayed as inline text, then the current byte
  assign st_a    = inline_step(s.isc, fc, s.isc.span_start);
  assign st_b    = inline_step(st_a.st, fc, p1);
  assign mid_st  = cnt2 ? st_b.st : st_a.st;
  assign use_b   = cnt2 && st_b.hit;
  assign rep_hit = st_a.hit || use_b;
  assign c_in    = cand ? mid_st : s.isc;
  assign st_c    = inline_step(c_in, text_byte, pos);

  always_comb begin
    nxt     = s;
    hit     = 1'b0;
    t_start = 12'd0;
    t_len   = s.col_count;
    t_type  = TT_CODE;
    if (closes_line) begin
      if (s.pclass == PC_FENCE || s.pclass == PC_CODE ||
          (s.code_block && (s.pclass == PC_SPACES || cand))) begin
        hit = 1'b1;
      end else if (s.pclass == PC_HEAD) begin
        hit    = 1'b1;
        t_type = TT_HEAD;
      end else if (cand) begin
        hit     = rep_hit;
        t_start = use_b ? st_b.start : st_a.start;
        t_len   = use_b ? st_b.len : st_a.len;
        t_type  = use_b ? st_b.typ : st_a.typ;
      end
      if (s.line_number < LINE_CAP) nxt.line_number = s.line_number + 16'd1;
      nxt.col_count = 13'd0;
      nxt.pclass    = PC_SPACES;
      nxt.isc       = ISCAN_RESET;
    end else begin
      if (s.col_count < COL_CAP) nxt.col_count = s.col_count + 13'd1;
      unique case (s.pclass)
        PC_SPACES: begin
          if (text_byte == CH_SPACE) begin
            nxt.isc.prev = CH_SPACE;
          end else if (text_byte == CH_BTICK || text_byte == CH_TILDE) begin
            nxt.pclass         = (text_byte == CH_BTICK) ? PC_BT1 : PC_TL1;
            nxt.isc.span_start = pos;
          end else if (text_byte == CH_HASH) begin
            nxt.pclass = s.code_block ? PC_CODE : PC_HEAD;
          end else if (s.code_block) begin
            nxt.pclass = PC_CODE;
          end else begin
            nxt.pclass = PC_INLINE;
            nxt.isc    = st_c.st;
            hit        = st_c.hit;
            t_start    = st_c.start;
            t_len      = st_c.len;
            t_type     = st_c.typ;
          end
        end
        PC_BT1, PC_BT2, PC_TL1, PC_TL2: begin
          if (text_byte == fc) begin
            if (s.pclass == PC_BT1) begin
              nxt.pclass = PC_BT2;
            end else if (s.pclass == PC_TL1) begin
              nxt.pclass = PC_TL2;
            end else begin
              nxt.pclass         = PC_FENCE;
              nxt.code_block     = ~s.code_block;
              nxt.isc.span_start = 12'd0;
            end
          end else if (s.code_block) begin
            nxt.pclass         = PC_CODE;
            nxt.isc.span_start = 12'd0;
          end else begin
            nxt.pclass = PC_INLINE;
            nxt.isc    = st_c.st;
            if (st_c.hit) begin
              hit     = 1'b1;
              t_start = st_c.start;
              t_len   = st_c.len;
              t_type  = st_c.typ;
            end else begin
              hit     = rep_hit;
              t_start = use_b ? st_b.start : st_a.start;
              t_len   = use_b ? st_b.len : st_a.len;
              t_type  = use_b ? st_b.typ : st_a.typ;
            end
          end
        end
        PC_INLINE: begin
          nxt.isc = st_c.st;
          hit     = st_c.hit;
          t_start = st_c.start;
          t_len   = st_c.len;
          t_type  = st_c.typ;
        end
        default: ;  // fence, code and heading lines only count columns
      endcase
    end
    if (hit) begin
      nxt.last_line = s.line_number;
      nxt.last_col  = t_start;
    end
  end

  assign dl = s.line_number - s.last_line;

  always_comb begin
    tok.hit          = hit;
    tok.row_delta    = dl;
    tok.col_delta    = (dl == 16'd0 && t_start >= s.last_col) ? t_start - s.last_col
                                                              : t_start;
    tok.token_length = t_len;
    tok.token_type   = t_type;
  end

endmodule
